@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk; ASSERT_CLK is disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, kept active during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/asbcd_pkg.sv @@
// ---------------------------------------------------------------------------
// asbcd_pkg
// Types and constants for the ASCII decimal to signed packed BCD parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package asbcd_pkg;

  localparam int BCD_DIGITS_DEF = 8;

  localparam int VALUE_W   = 32;
  localparam int CONSUME_W = 16;
  localparam int CHAR_W    = 8;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,  // done, waiting for start
    PH_LEAD   = 2'd1,  // skipping blanks, sign allowed
    PH_FIRST  = 2'd2,  // first digit required
    PH_DIGITS = 2'd3   // packing digits
  } phase_t;

  typedef struct packed {
    logic [CONSUME_W-1:0] consumed;
    logic                 error;
    logic [VALUE_W-1:0]   bcd_value;
  } result_t;

endpackage

@@ sv/ascii_to_signed_bcd_parser_top.sv @@
// ---------------------------------------------------------------------------
// ascii_to_signed_bcd_parser_top
// Parses a stream of ASCII characters into signed packed BCD numbers.
// ---------------------------------------------------------------------------
//
//  channel | dir | tdata                          | tuser
//  --------+-----+--------------------------------+-----------
//  in_     | in  | [7:0] ch                       | start_req
//  out_    | out | [31:0] bcd_value,[47:32] consumed | error
//
//  One character request per cycle while in_tready is high; the parse state register
//  is updated in the same cycle the request is taken.
//  A result is registered into the head slot on its ending character, or into the skid slot while the head is stalled.
//  Head register plus one skid register on the result side: input keeps
//  flowing while one result is stalled, in_tready drops only when both hold.
//  rst_n is synchronous, active low; it clears the parse state and the valid
//  flags of both result slots. No clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ascii_to_signed_bcd_parser_top #(
  parameter int BCD_DIGITS = asbcd_pkg::BCD_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input character channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] start_req
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] bcd_value, [47:32] consumed
  output logic        out_tuser   // [0] error
);

  import asbcd_pkg::*;

  localparam int ACC_W = 4 * BCD_DIGITS;

  // parse state
  phase_t               phase_r, phase_nxt;
  logic                 neg_r, neg_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CONSUME_W-1:0] cnt_r, cnt_nxt;

  // result slots
  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t head_r, head_nxt;
  result_t skid_r, skid_nxt;

  logic    in_acc;
  logic    pop;
  logic    emit;
  result_t res;

  logic [ACC_W-1:0]       comp;
  logic [ACC_W+VALUE_W-1:0] val_ext;

  assign in_tready = !skid_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign pop       = out_v_r && out_tready;

  // nine's complement, digit by digit
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      comp[4*i +: 4] = 4'd9 - acc_r[4*i +: 4];
    end
  end

  assign val_ext = {{VALUE_W{1'b0}}, (neg_r ? comp : acc_r)};

  // one character step
  always_comb begin
    phase_t               ph;
    logic                 neg;
    logic [ACC_W-1:0]     acc;
    logic                 ovf;
    logic [CONSUME_W-1:0] cnt;
    logic                 is_digit;
    logic                 is_blank;
    logic [3:0]           dig;

    ph  = phase_r;
    neg = neg_r;
    acc = acc_r;
    ovf = ovf_r;
    cnt = cnt_r;
    emit = 1'b0;
    res  = '0;

    is_digit = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
    is_blank = (in_tdata == CH_SPACE) || (in_tdata == CH_TAB);
    dig      = in_tdata[3:0];

    if (in_tuser) begin
      ph  = PH_LEAD;
      neg = 1'b0;
      acc = '0;
      ovf = 1'b0;
      cnt = '0;
    end

    case (ph)
      PH_IDLE: begin
      end
      PH_LEAD, PH_FIRST: begin
        if (ph == PH_LEAD && is_blank) begin
          if (cnt != '1) cnt = cnt + 1'b1;
        end else if (ph == PH_LEAD &&
                     (in_tdata == CH_MINUS || in_tdata == CH_PLUS)) begin
          neg = (in_tdata == CH_MINUS);
          if (cnt != '1) cnt = cnt + 1'b1;
          ph  = PH_FIRST;
        end else if (is_digit) begin
          acc = ACC_W'(dig);
          if (cnt != '1) cnt = cnt + 1'b1;
          ph  = PH_DIGITS;
        end else begin
          // no digit after blanks and sign
          emit          = 1'b1;
          res.bcd_value = '0;
          res.error     = 1'b1;
          res.consumed  = '0;
          ph            = PH_IDLE;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          if (cnt != '1) cnt = cnt + 1'b1;
          if (!ovf) begin
            if (acc[ACC_W-1 -: 4] != 4'd0) begin
              ovf = 1'b1;
              acc = '0;
            end else begin
              acc = (acc << 4) | ACC_W'(dig);
            end
          end
        end else begin
          emit          = 1'b1;
          res.error     = ovf;
          res.bcd_value = ovf ? '0 : val_ext[VALUE_W-1:0];
          res.consumed  = cnt;
          ph            = PH_IDLE;
        end
      end
      default: begin
        ph = PH_IDLE;
      end
    endcase

    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    cnt_nxt   = cnt_r;
    if (in_acc) begin
      phase_nxt = ph;
      neg_nxt   = neg;
      acc_nxt   = acc;
      ovf_nxt   = ovf;
      cnt_nxt   = cnt;
    end
  end

  // head + skid result slots
  always_comb begin
    logic push;
    push       = in_acc && emit;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      // input stalled here, no push possible
      if (pop) begin
        head_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (out_v_r && !pop) begin
      if (push) begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end else begin
      out_v_nxt = push;
      if (push) head_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      neg_r    <= 1'b0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      cnt_r    <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      cnt_r    <= cnt_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {head_r.consumed, head_r.bcd_value};
  assign out_tuser  = head_r.error;

  // checks
  `ASSERT_ALWAYS(a_skid_has_head, (!rst_n || !skid_v_r || out_v_r), "skid valid without head")
  `ASSERT_CLK(a_err_zero_value, (out_v_r && head_r.error) |-> (head_r.bcd_value == '0), "error result with nonzero value")
  `ASSERT_CLK(a_ovf_acc_clear, (phase_r == PH_DIGITS && ovf_r) |-> (acc_r == '0), "overflow left accumulator nonzero")
  `ASSERT_CLK(a_idle_no_emit, (in_acc && !in_tuser && phase_r == PH_IDLE) |=> (out_v_r == $past(out_v_r && !pop) || skid_v_r), "result from idle phase")

endmodule
